FILE: hw/rtl/thca_pkg.sv
// Shared constants, types and the arctangent table for the tilt-compensated
// heading averager. No dependencies; every other source file but thca_if.sv imports it.
package thca_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    // CORDIC datapath widths: x and y carry a 2^16 pre-scale plus gain growth.
    localparam int CW = 50;
    localparam int ZW = 34;

    // Bit-serial multiplier operand widths.
    localparam int MA_W  = 33;
    localparam int MB_W  = 17;
    localparam int MP_W  = 50;
    localparam int MB_CW = $clog2(MB_W);

    // Bit-serial divider and square root.
    localparam int DIV_N_W     = 30;
    localparam int DIV_CW      = $clog2(DIV_N_W);
    localparam int SQRT_V_W    = 29;
    localparam int SQRT_STEPS  = 15;
    localparam int SQRT_CW     = $clog2(SQRT_STEPS);

    localparam logic [11:0]          G_Q8        = 12'd2511;
    localparam logic [14:0]          ONE_Q14     = 15'd16384;
    localparam logic signed [24:0]   SUM_MAX     = 25'sd8388607;
    localparam logic signed [24:0]   SUM_MIN     = -25'sd8388608;
    localparam logic [31:0]          KGAIN_Q30   = 32'd652032875;
    localparam logic [31:0]          HALF_TURN   = 32'h8000_0000;
    localparam logic [31:0]          QUARTER_TURN = 32'h4000_0000;
    localparam logic [16:0]          DEG_SCALE   = 17'd36000;
    localparam logic signed [16:0]   NOT_READY_CD = -17'sd100;

    // CORDIC mode codes.
    localparam logic CORDIC_ROT = 1'b0;
    localparam logic CORDIC_VEC = 1'b1;

    typedef struct packed {
        logic               start;
        logic               vec_mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        angle;
    } cordic_req_t;

    typedef struct packed {
        logic               done;
        logic [31:0]        angle;
        logic signed [15:0] cos_q;
        logic signed [15:0] sin_q;
    } cordic_rsp_t;

    // atan(2^-i) as a fraction of one turn times 2^32.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/thca_if.sv
// Valid/ready channel interfaces for sample items and heading result items.
// Depends on nothing but the port conventions of the top level.
interface thca_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic               last_sample;

    modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                    last_sample, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z,
                    last_sample, output ready);
endinterface

interface thca_result_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] heading_centideg;

    modport source (output valid, heading_centideg, input ready);
    modport sink   (input valid, heading_centideg, output ready);
endinterface

FILE: hw/rtl/thca_mul.sv
// Bit-serial signed multiplier: one bit of the second operand per cycle.
// Depends on thca_pkg for operand widths.
module thca_mul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [thca_pkg::MA_W-1:0]  a,
    input  logic signed [thca_pkg::MB_W-1:0]  b,
    output logic                              done,
    output logic signed [thca_pkg::MP_W-1:0]  p
);
    import thca_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [MB_CW-1:0]        cnt_reg, cnt_next;
    logic signed [MP_W-1:0]  a_sh_reg, a_sh_next;
    logic [MB_W-1:0]         b_sh_reg, b_sh_next;
    logic signed [MP_W-1:0]  acc_reg, acc_next;
    logic signed [MP_W-1:0]  term;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        acc_next  = acc_reg;
        term      = b_sh_reg[0] ? a_sh_reg : '0;
        if (busy_reg)
        begin
            // The top bit of b carries negative weight.
            if (cnt_reg == MB_CW'(MB_W - 1))
            begin
                acc_next  = acc_reg - term;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                acc_next = acc_reg + term;
            end
            a_sh_next = a_sh_reg <<< 1;
            b_sh_next = b_sh_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_sh_next = MP_W'(a);
            b_sh_next = b;
            acc_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

FILE: hw/rtl/thca_div.sv
// Restoring divider by the constant g, one quotient bit per cycle.
// Depends on thca_pkg for G_Q8 and widths.
module thca_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [thca_pkg::DIV_N_W-1:0]   num,
    output logic                           done,
    output logic [thca_pkg::DIV_N_W-1:0]   quot
);
    import thca_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CW-1:0]    cnt_reg, cnt_next;
    logic [12:0]          rem_reg, rem_next;
    logic [DIV_N_W-1:0]   n_sh_reg, n_sh_next;
    logic [DIV_N_W-1:0]   q_sh_reg, q_sh_next;
    logic [12:0]          trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        n_sh_next = n_sh_reg;
        q_sh_next = q_sh_reg;
        trial     = {rem_reg[11:0], n_sh_reg[DIV_N_W-1]};
        if (busy_reg)
        begin
            if (trial >= 13'(G_Q8))
            begin
                rem_next  = trial - 13'(G_Q8);
                q_sh_next = {q_sh_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                q_sh_next = {q_sh_reg[DIV_N_W-2:0], 1'b0};
            end
            n_sh_next = n_sh_reg << 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            n_sh_next = num;
            q_sh_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        n_sh_reg <= n_sh_next;
        q_sh_reg <= q_sh_next;
    end

    assign done = done_reg;
    assign quot = q_sh_reg;

endmodule

FILE: hw/rtl/thca_sqrt.sv
// Integer square root, two radicand bits per cycle (floor result).
// Depends on thca_pkg for widths.
module thca_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [thca_pkg::SQRT_V_W-1:0]   v,
    output logic                            done,
    output logic [14:0]                     root
);
    import thca_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [SQRT_CW-1:0]    cnt_reg, cnt_next;
    logic [SQRT_V_W-1:0]   rem_reg, rem_next;
    logic [SQRT_V_W:0]     res_reg, res_next;
    logic [SQRT_V_W-1:0]   bit_reg, bit_next;
    logic [SQRT_V_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        trial     = res_reg + {1'b0, bit_reg};
        if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[SQRT_V_W-1:0];
                res_next = (res_reg >> 1) + {1'b0, bit_reg};
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SQRT_CW'(SQRT_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = v;
            res_next  = '0;
            bit_next  = {1'b1, {(SQRT_V_W-1){1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[14:0];

endmodule

FILE: hw/rtl/thca_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, in vectoring or rotation mode.
// Depends on thca_pkg for widths, the arctangent table and request types.
module thca_cordic (
    input  logic                   clk,
    input  logic                   rst_n,
    input  thca_pkg::cordic_req_t  req,
    output thca_pkg::cordic_rsp_t  rsp
);
    import thca_pkg::*;

    localparam logic signed [CW-1:0] Q_MAX = CW'(16384);
    localparam logic signed [CW-1:0] Q_MIN = -CW'(16384);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic signed [CW-1:0]  x_reg, x_next;
    logic signed [CW-1:0]  y_reg, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic                  vec_reg, vec_next;
    logic                  zero_reg, zero_next;
    logic                  neg_reg, neg_next;

    logic signed [CW-1:0]  xs, ys, x_in, y_in;
    logic signed [ZW-1:0]  at;
    logic                  sel;
    logic [31:0]           folded, tq;
    logic signed [15:0]    cq, sq;

    function automatic logic signed [15:0] to_q14(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + CW'(32768)) >>> 16;
        if (r > Q_MAX)
        begin
            r = Q_MAX;
        end
        if (r < Q_MIN)
        begin
            r = Q_MIN;
        end
        return 16'(r);
    endfunction

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        vec_next  = vec_reg;
        zero_next = zero_reg;
        neg_next  = neg_reg;
        xs        = x_reg >>> cnt_reg;
        ys        = y_reg >>> cnt_reg;
        at        = signed'({{(ZW-32){1'b0}}, atan_turn(5'(cnt_reg))});
        // Vectoring drives y toward zero; rotation drives z toward zero.
        sel       = vec_reg ? y_reg[CW-1] : ~z_reg[ZW-1];
        x_in      = CW'(req.x) <<< 16;
        y_in      = CW'(req.y) <<< 16;
        tq        = req.angle + QUARTER_TURN;
        folded    = tq[31] ? req.angle - HALF_TURN : req.angle;
        if (busy_reg)
        begin
            if (sel)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            vec_next  = req.vec_mode;
            if (req.vec_mode == CORDIC_VEC)
            begin
                zero_next = (req.x == 32'sd0) && (req.y == 32'sd0);
                neg_next  = 1'b0;
                if (req.x[31])
                begin
                    x_next = -x_in;
                    y_next = -y_in;
                    z_next = signed'(ZW'(HALF_TURN));
                end
                else
                begin
                    x_next = x_in;
                    y_next = y_in;
                    z_next = '0;
                end
            end
            else
            begin
                zero_next = 1'b0;
                neg_next  = tq[31];
                x_next    = signed'(CW'(KGAIN_Q30));
                y_next    = '0;
                z_next    = ZW'(signed'(folded));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        vec_reg  <= vec_next;
        zero_reg <= zero_next;
        neg_reg  <= neg_next;
    end

    always_comb
    begin
        cq        = to_q14(x_reg);
        sq        = to_q14(y_reg);
        rsp.done  = done_reg;
        rsp.angle = zero_reg ? 32'd0 : z_reg[31:0];
        rsp.cos_q = neg_reg ? -cq : cq;
        rsp.sin_q = neg_reg ? -sq : sq;
    end

endmodule

FILE: hw/rtl/tilt_compensated_heading_average.sv
// Tilt-compensated compass heading, averaged as a vector mean over a run.
// Each sample is paced by the one shared bit-serial multiplier (eight products)
// plus the divider, the root and four 16-step CORDIC passes; the last sample
// adds a further CORDIC pass and a product for the mean.
// While not ready a sample is dropped in S_IDLE; a last one goes on to S_EMIT.
// Reset (rst_n, asynchronous) clears sensor_ready, both sums and all control.
module tilt_compensated_heading_average (
    input  logic                 clk,
    input  logic                 rst_n,
    thca_sample_if.sink          sample,
    thca_result_if.source        result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import thca_pkg::*;

    // Byte address of the sensor_ready register.
    localparam logic [2:0] ADDR_SENSOR_READY = 3'd0;

    // Sequencer states: each working state launches one unit and waits for it.
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DIV   = 5'd1;
    localparam logic [4:0] S_MSQ   = 5'd2;
    localparam logic [4:0] S_SQRT  = 5'd3;
    localparam logic [4:0] S_ROLLV = 5'd4;
    localparam logic [4:0] S_ROLLR = 5'd5;
    localparam logic [4:0] S_M1    = 5'd6;
    localparam logic [4:0] S_M2    = 5'd7;
    localparam logic [4:0] S_M3    = 5'd8;
    localparam logic [4:0] S_M4    = 5'd9;
    localparam logic [4:0] S_M5    = 5'd10;
    localparam logic [4:0] S_M6    = 5'd11;
    localparam logic [4:0] S_M7    = 5'd12;
    localparam logic [4:0] S_HV    = 5'd13;
    localparam logic [4:0] S_HR    = 5'd14;
    localparam logic [4:0] S_MV    = 5'd15;
    localparam logic [4:0] S_MC    = 5'd16;
    localparam logic [4:0] S_EMIT  = 5'd17;

    // Control state.
    logic [4:0]          state_reg, state_next;
    logic                go_reg, go_next;
    logic                ready_cfg_reg, ready_cfg_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [23:0]  sine_sum_reg, sine_sum_next;
    logic signed [23:0]  cosine_sum_reg, cosine_sum_next;

    // Sample and intermediate payload.
    logic signed [15:0]  ax_reg, ay_reg, az_reg, mx_reg, my_reg, mz_reg;
    logic                last_reg;
    logic signed [15:0]  sp_reg, sp_next;
    logic signed [15:0]  cp_reg, cp_next;
    logic signed [15:0]  cr_reg, cr_next;
    logic signed [15:0]  sr_reg, sr_next;
    logic [SQRT_V_W-1:0] sqv_reg, sqv_next;
    logic signed [31:0]  xh_reg, xh_next;
    logic signed [31:0]  yh_reg, yh_next;
    logic signed [31:0]  t_reg, t_next;
    logic [31:0]         angle_reg, angle_next;
    logic signed [16:0]  pend_reg, pend_next;
    logic signed [16:0]  res_reg, res_next;

    // Unit hookup.
    logic                    mul_start, mul_done;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  mul_p;
    logic                    div_start, div_done;
    logic [DIV_N_W-1:0]      div_num, div_q;
    logic                    sqrt_start, sqrt_done;
    logic [14:0]             sqrt_root;
    logic                    cordic_start;
    cordic_req_t             creq;
    cordic_rsp_t             crsp;

    logic                    in_fire, out_fire, cfg_wr;
    logic signed [16:0]      ax_ext, ax_abs;
    logic [14:0]             mag_sat;
    logic signed [24:0]      s_sum, c_sum;
    logic signed [MP_W-1:0]  cd_full;
    logic [16:0]             cd;

    thca_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    thca_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .done  (div_done),
        .quot  (div_q)
    );

    thca_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .v     (sqv_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    thca_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    // The block takes a sample only between runs of the sequencer.
    assign sample.ready = (state_reg == S_IDLE);
    assign in_fire      = sample.valid && sample.ready;
    assign result.valid = out_valid_reg;
    assign result.heading_centideg = res_reg;
    assign out_fire     = result.valid && result.ready;

    // Configuration port: only register 0 (sensor_ready) exists.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == ADDR_SENSOR_READY) ? {31'd0, ready_cfg_reg} : 32'd0;

    // |accel_x| scaled by 2^14 feeds the divider; the quotient is |sin(pitch)|.
    assign ax_ext  = {ax_reg[15], ax_reg};
    assign ax_abs  = ax_reg[15] ? -ax_ext : ax_ext;
    assign div_num = {ax_abs[15:0], 14'd0};
    assign mag_sat = (div_q > DIV_N_W'(ONE_Q14)) ? ONE_Q14 : div_q[14:0];

    assign cd_full = mul_p + MP_W'(HALF_TURN);
    assign cd      = cd_full[48:32];

    // Operand selection for the shared multiplier and the CORDIC.
    always_comb
    begin
        unique case (state_reg)
            S_MSQ:   begin mul_a = MA_W'(sp_reg); mul_b = MB_W'(sp_reg); end
            S_M1:    begin mul_a = MA_W'(mx_reg); mul_b = MB_W'(cp_reg); end
            S_M2:    begin mul_a = MA_W'(mz_reg); mul_b = MB_W'(sp_reg); end
            S_M3:    begin mul_a = MA_W'(mx_reg); mul_b = MB_W'(sr_reg); end
            S_M4:    begin mul_a = MA_W'(t_reg);  mul_b = MB_W'(sp_reg); end
            S_M5:    begin mul_a = MA_W'(my_reg); mul_b = MB_W'(cr_reg); end
            S_M6:    begin mul_a = MA_W'(mz_reg); mul_b = MB_W'(sr_reg); end
            S_M7:    begin mul_a = MA_W'(t_reg);  mul_b = MB_W'(cp_reg); end
            S_MC:    begin mul_a = signed'({1'b0, angle_reg}); mul_b = signed'(DEG_SCALE); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase

        creq.start    = cordic_start;
        creq.vec_mode = CORDIC_VEC;
        creq.angle    = angle_reg;
        unique case (state_reg)
            S_ROLLV:
            begin
                creq.x = 32'(az_reg);
                creq.y = 32'(ay_reg);
            end
            S_HV:
            begin
                creq.x = xh_reg;
                creq.y = yh_reg;
            end
            S_MV:
            begin
                creq.x = 32'(cosine_sum_reg);
                creq.y = 32'(sine_sum_reg);
            end
            default:
            begin
                creq.vec_mode = CORDIC_ROT;
                creq.x = '0;
                creq.y = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        go_next         = go_reg;
        ready_cfg_next  = ready_cfg_reg;
        out_valid_next  = out_valid_reg;
        sine_sum_next   = sine_sum_reg;
        cosine_sum_next = cosine_sum_reg;
        sp_next         = sp_reg;
        cp_next         = cp_reg;
        cr_next         = cr_reg;
        sr_next         = sr_reg;
        sqv_next        = sqv_reg;
        xh_next         = xh_reg;
        yh_next         = yh_reg;
        t_next          = t_reg;
        angle_next      = angle_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        mul_start       = 1'b0;
        div_start       = 1'b0;
        sqrt_start      = 1'b0;
        cordic_start    = 1'b0;
        s_sum           = 25'(sine_sum_reg) + 25'(crsp.sin_q);
        c_sum           = 25'(cosine_sum_reg) + 25'(crsp.cos_q);

        if (cfg_wr && paddr == ADDR_SENSOR_READY)
        begin
            ready_cfg_next = pwdata[0];
        end
        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        // Each working state first launches its unit, then waits for done.
        if (state_reg != S_IDLE && state_reg != S_EMIT && !go_reg)
        begin
            go_next = 1'b1;
            unique case (state_reg)
                S_DIV:   div_start    = 1'b1;
                S_SQRT:  sqrt_start   = 1'b1;
                S_ROLLV, S_ROLLR, S_HV, S_HR, S_MV: cordic_start = 1'b1;
                default: mul_start    = 1'b1;
            endcase
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (ready_cfg_reg)
                        begin
                            state_next = S_DIV;
                        end
                        else if (sample.last_sample)
                        begin
                            // Not ready: the run ends with minus one degree.
                            sine_sum_next   = '0;
                            cosine_sum_next = '0;
                            pend_next       = NOT_READY_CD;
                            state_next      = S_EMIT;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        sp_next    = ax_reg[15] ? signed'({1'b0, mag_sat})
                                                : -signed'({1'b0, mag_sat});
                        go_next    = 1'b0;
                        state_next = S_MSQ;
                    end
                end
                S_MSQ:
                begin
                    if (mul_done)
                    begin
                        sqv_next   = {1'b1, {(SQRT_V_W-1){1'b0}}} - mul_p[SQRT_V_W-1:0];
                        go_next    = 1'b0;
                        state_next = S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        cp_next    = signed'({1'b0, sqrt_root});
                        go_next    = 1'b0;
                        state_next = S_ROLLV;
                    end
                end
                S_ROLLV:
                begin
                    if (crsp.done)
                    begin
                        angle_next = crsp.angle;
                        go_next    = 1'b0;
                        state_next = S_ROLLR;
                    end
                end
                S_ROLLR:
                begin
                    if (crsp.done)
                    begin
                        cr_next    = crsp.cos_q;
                        sr_next    = crsp.sin_q;
                        go_next    = 1'b0;
                        state_next = S_M1;
                    end
                end
                S_M1:
                begin
                    if (mul_done)
                    begin
                        xh_next    = 32'(mul_p);
                        go_next    = 1'b0;
                        state_next = S_M2;
                    end
                end
                S_M2:
                begin
                    if (mul_done)
                    begin
                        xh_next    = xh_reg + 32'(mul_p);
                        go_next    = 1'b0;
                        state_next = S_M3;
                    end
                end
                S_M3:
                begin
                    if (mul_done)
                    begin
                        t_next     = 32'(mul_p);
                        go_next    = 1'b0;
                        state_next = S_M4;
                    end
                end
                S_M4:
                begin
                    if (mul_done)
                    begin
                        yh_next    = 32'(mul_p >>> 14);
                        go_next    = 1'b0;
                        state_next = S_M5;
                    end
                end
                S_M5:
                begin
                    if (mul_done)
                    begin
                        yh_next    = yh_reg + 32'(mul_p);
                        go_next    = 1'b0;
                        state_next = S_M6;
                    end
                end
                S_M6:
                begin
                    if (mul_done)
                    begin
                        t_next     = 32'(mul_p);
                        go_next    = 1'b0;
                        state_next = S_M7;
                    end
                end
                S_M7:
                begin
                    if (mul_done)
                    begin
                        yh_next    = yh_reg - 32'(mul_p >>> 14);
                        go_next    = 1'b0;
                        state_next = S_HV;
                    end
                end
                S_HV:
                begin
                    if (crsp.done)
                    begin
                        angle_next = crsp.angle;
                        go_next    = 1'b0;
                        state_next = S_HR;
                    end
                end
                S_HR:
                begin
                    if (crsp.done)
                    begin
                        // Saturating accumulation of the heading's unit vector.
                        if (s_sum > SUM_MAX)
                        begin
                            sine_sum_next = 24'(SUM_MAX);
                        end
                        else if (s_sum < SUM_MIN)
                        begin
                            sine_sum_next = 24'(SUM_MIN);
                        end
                        else
                        begin
                            sine_sum_next = 24'(s_sum);
                        end
                        if (c_sum > SUM_MAX)
                        begin
                            cosine_sum_next = 24'(SUM_MAX);
                        end
                        else if (c_sum < SUM_MIN)
                        begin
                            cosine_sum_next = 24'(SUM_MIN);
                        end
                        else
                        begin
                            cosine_sum_next = 24'(c_sum);
                        end
                        go_next    = 1'b0;
                        state_next = last_reg ? S_MV : S_IDLE;
                    end
                end
                S_MV:
                begin
                    if (crsp.done)
                    begin
                        angle_next = crsp.angle;
                        go_next    = 1'b0;
                        state_next = S_MC;
                    end
                end
                S_MC:
                begin
                    if (mul_done)
                    begin
                        // A full turn rounds back to zero.
                        pend_next       = (cd >= DEG_SCALE) ? 17'sd0 : signed'(cd);
                        sine_sum_next   = '0;
                        cosine_sum_next = '0;
                        go_next         = 1'b0;
                        state_next      = S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // Wait for the output register to free up.
                    if (!out_valid_reg || out_fire)
                    begin
                        res_next       = pend_reg;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                    go_next    = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            go_reg         <= 1'b0;
            ready_cfg_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            sine_sum_reg   <= '0;
            cosine_sum_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            go_reg         <= go_next;
            ready_cfg_reg  <= ready_cfg_next;
            out_valid_reg  <= out_valid_next;
            sine_sum_reg   <= sine_sum_next;
            cosine_sum_reg <= cosine_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ax_reg   <= sample.accel_x;
            ay_reg   <= sample.accel_y;
            az_reg   <= sample.accel_z;
            mx_reg   <= sample.mag_x;
            my_reg   <= sample.mag_y;
            mz_reg   <= sample.mag_z;
            last_reg <= sample.last_sample;
        end
        sp_reg    <= sp_next;
        cp_reg    <= cp_next;
        cr_reg    <= cr_next;
        sr_reg    <= sr_next;
        sqv_reg   <= sqv_next;
        xh_reg    <= xh_next;
        yh_reg    <= yh_next;
        t_reg     <= t_next;
        angle_reg <= angle_next;
        pend_reg  <= pend_next;
        res_reg   <= res_next;
    end

endmodule

FILE: test/tb_top.sv
// Testbench for the tilt-compensated heading averager: random and directed
// sensor samples, a bit-accurate heading predictor and an in-order checker.
// Depends on thca_pkg and the channel interfaces in hw/rtl.
module tb_top;
    import thca_pkg::*;

    // A sample item as the driver holds it.
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
        logic               last;
    } sample_t;

    // Register index of the only configuration register, and one that is unused.
    localparam logic [2:0] REG_SENSOR_READY = 3'd0;
    localparam logic [2:0] REG_UNUSED       = 3'd1;
    localparam int         TIMEOUT_CYCLES   = 2_000_000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    thca_sample_if sample_ch ();
    thca_result_if result_ch ();

    tilt_compensated_heading_average i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch.sink),
        .result  (result_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: its own copy of the register and the two running sums.
    logic                ready_reg;
    longint              sin_acc;
    longint              cos_acc;

    sample_t             sample_queue[$];
    logic signed [16:0]  heading_queue[$];
    int                  error_count;
    longint              cycle_count;
    bit                  quiet_tail;
    bit                  stimulus_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Floor right shift on signed values, whatever the operand sign.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Integer square root, rounded down.
    function automatic longint int_root(longint v);
        longint r;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v)
            begin
                r = r + (64'sd1 << b);
            end
        end
        return r;
    endfunction

    // Vectoring CORDIC: binary angle of the vector (x, y), one turn = 2^32.
    function automatic logic [31:0] vector_angle(longint x, longint y);
        logic [31:0] z;
        longint dx;
        longint dy;
        z = 32'd0;
        if (x == 0 && y == 0)
        begin
            return 32'd0;
        end
        x = x * 65536;
        y = y * 65536;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y < 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turn(i[4:0]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turn(i[4:0]);
            end
        end
        return z;
    endfunction

    // Rounds a Q2.30 CORDIC output half up to Q1.14 and clamps it to one.
    function automatic longint round_q14(longint v);
        longint r;
        r = floor_shift(v + 32768, 16);
        if (r > 16384)
        begin
            r = 16384;
        end
        if (r < -16384)
        begin
            r = -16384;
        end
        return r;
    endfunction

    // Rotation CORDIC, folded into [-90, 90) degrees first.
    task automatic rotate_unit(input logic [31:0] a, output longint c, output longint s);
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic [31:0] shifted;
        flip = 1'b0;
        x = KGAIN_Q30;
        y = 0;
        shifted = a + QUARTER_TURN;
        if (shifted >= HALF_TURN)
        begin
            a = a - HALF_TURN;
            flip = 1'b1;
        end
        z = (a >= HALF_TURN) ? longint'(a) - 64'sd4294967296 : longint'(a);
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_turn(i[4:0]));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_turn(i[4:0]));
            end
        end
        c = round_q14(x);
        s = round_q14(y);
        if (flip)
        begin
            c = -c;
            s = -s;
        end
    endtask

    function automatic longint clamp_sum(longint v);
        if (v > 8388607)
        begin
            return 8388607;
        end
        if (v < -8388608)
        begin
            return -8388608;
        end
        return v;
    endfunction

    // Advances the heading predictor by one accepted sample. A sample marked
    // last queues its expected heading (-1 degree if not ready) and clears the sums.
    task automatic predict_heading(input sample_t smp);
        longint num;
        longint mag;
        longint sp;
        longint cp;
        longint cr;
        longint sr;
        longint xh;
        longint yh;
        longint hc;
        longint hs;
        longint cd;
        if (!ready_reg)
        begin
            if (smp.last)
            begin
                heading_queue.push_back(NOT_READY_CD);
                sin_acc = 0;
                cos_acc = 0;
            end
            return;
        end
        // Pitch sine from the ratio to g, saturated at one; the cosine is a floor root.
        num = -longint'(smp.ax) * 16384;
        mag = (num < 0) ? -num : num;
        mag = mag / 2511;
        if (mag > 16384)
        begin
            mag = 16384;
        end
        sp = (num < 0) ? -mag : mag;
        cp = int_root(268435456 - sp * sp);
        rotate_unit(vector_angle(smp.az, smp.ay), cr, sr);
        // Field rotated into the horizontal plane.
        xh = longint'(smp.mx) * cp + longint'(smp.mz) * sp;
        yh = floor_shift(longint'(smp.mx) * sr * sp, 14) + longint'(smp.my) * cr
             - floor_shift(longint'(smp.mz) * sr * cp, 14);
        rotate_unit(vector_angle(xh, yh), hc, hs);
        sin_acc = clamp_sum(sin_acc + hs);
        cos_acc = clamp_sum(cos_acc + hc);
        if (smp.last)
        begin
            cd = (longint'(vector_angle(cos_acc, sin_acc)) * 36000 + 64'sh8000_0000) >>> 32;
            if (cd >= 36000)
            begin
                cd = 0;
            end
            heading_queue.push_back(17'(cd));
            sin_acc = 0;
            cos_acc = 0;
        end
    endtask

    // Driver: presents the oldest pending item, with random idle bursts.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                predict_heading(sample_queue.pop_front());
            end
            if (!(sample_ch.valid && !sample_ch.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    sample_ch.valid <= 1'b0;
                end
                else if (sample_queue.size() > 0)
                begin
                    if (!quiet_tail && $urandom_range(0, 9) == 0)
                    begin
                        send_gap = $urandom_range(1, 8);
                        sample_ch.valid <= 1'b0;
                    end
                    else
                    begin
                        sample_ch.valid       <= 1'b1;
                        sample_ch.accel_x     <= sample_queue[0].ax;
                        sample_ch.accel_y     <= sample_queue[0].ay;
                        sample_ch.accel_z     <= sample_queue[0].az;
                        sample_ch.mag_x       <= sample_queue[0].mx;
                        sample_ch.mag_y       <= sample_queue[0].my;
                        sample_ch.mag_z       <= sample_queue[0].mz;
                        sample_ch.last_sample <= sample_queue[0].last;
                    end
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result against the oldest expected heading and
    // stalls the result channel in random bursts.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (heading_queue.size() == 0)
                begin
                    $error("unexpected result: heading_centideg actual %0d",
                           result_ch.heading_centideg);
                    error_count++;
                end
                else if (result_ch.heading_centideg !== heading_queue[0])
                begin
                    $error("heading_centideg mismatch: expected %0d actual %0d",
                           heading_queue[0], result_ch.heading_centideg);
                    error_count++;
                    void'(heading_queue.pop_front());
                end
                else
                begin
                    void'(heading_queue.pop_front());
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 8);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Cycle limit: the slowest correct run is about 1700 samples
    // with gaps and stalls.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Register write through the setup and access phases.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx[0], 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SENSOR_READY)
        begin
            ready_reg = val[0];
        end
    endtask

    // Waits until every queued item is taken and every result has come, then
    // lets the block finish any sample still in flight (no result pending).
    task automatic drain();
        while (sample_queue.size() > 0 || sample_ch.valid || heading_queue.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($signed($urandom_range(0, 2 * 2560)) - 2560);
        endcase
    endfunction

    function automatic sample_t make_sample(bit last);
        sample_t s;
        s.ax = rand_field();
        s.ay = rand_field();
        s.az = rand_field();
        s.mx = rand_field();
        s.my = rand_field();
        s.mz = rand_field();
        s.last = last;
        return s;
    endfunction

    // Queues one averaging run of len random samples, the final one marked last.
    task automatic queue_run(input int len);
        for (int k = 0; k < len; k++)
        begin
            sample_queue.push_back(make_sample(k == len - 1));
        end
    endtask

    initial
    begin
        sample_t s;
        int      sent;
        error_count = 0;
        cycle_count = 0;
        quiet_tail = 1'b0;
        ready_reg = 1'b0;
        sin_acc = 0;
        cos_acc = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        sample_ch.valid = 1'b0;
        sample_ch.accel_x = 16'sd0;
        sample_ch.accel_y = 16'sd0;
        sample_ch.accel_z = 16'sd0;
        sample_ch.mag_x = 16'sd0;
        sample_ch.mag_y = 16'sd0;
        sample_ch.mag_z = 16'sd0;
        sample_ch.last_sample = 1'b0;
        result_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Not ready after reset: samples are dropped, a last one gives -1 degree.
        queue_run(3);
        queue_run(1);
        drain();

        // A write to an unused register index must be ignored.
        write_reg(REG_UNUSED, 32'd1);
        queue_run(2);
        drain();

        write_reg(REG_SENSOR_READY, 32'hFFFF_FFFF);
        // Directed: zero vectors everywhere, pitch saturation both ways,
        // extreme fields, and an empty-looking cancelling pair.
        s = '0;
        s.last = 1'b1;
        sample_queue.push_back(s);
        s = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0};
        sample_queue.push_back(s);
        s = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1};
        sample_queue.push_back(s);
        s = '{16'sd2511, 16'sd0, 16'sd0, 16'sd5000, 16'sd0, 16'sd100, 1'b1};
        sample_queue.push_back(s);
        s = '{-16'sd2511, 16'sd0, -16'sd2511, 16'sd0, 16'sd5000, 16'sd0, 1'b1};
        sample_queue.push_back(s);
        s = '{16'sd0, 16'sd0, 16'sd2511, 16'sd4000, 16'sd0, 16'sd0, 1'b0};
        sample_queue.push_back(s);
        s = '{16'sd0, 16'sd0, 16'sd2511, -16'sd4000, 16'sd0, 16'sd0, 1'b1};
        sample_queue.push_back(s);
        s = '{16'sd0, 16'sd0, 16'sd2511, 16'sd3000, -16'sd1, 16'sd0, 1'b1};
        sample_queue.push_back(s);
        s = '{16'sd3000, -16'sd3000, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b1};
        sample_queue.push_back(s);
        drain();

        // Random runs, switching the ready register between phases.
        sent = 0;
        while (sent < 1700)
        begin
            int len;
            if (sent > 1500)
            begin
                quiet_tail = 1'b1;
            end
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(260, 300)
                                               : $urandom_range(1, 12);
            queue_run(len);
            sent += len;
            if (sample_queue.size() > 60)
            begin
                drain();
                if ($urandom_range(0, 7) == 0)
                begin
                    write_reg(REG_SENSOR_READY, 32'd0);
                    queue_run(4);
                    drain();
                    write_reg(REG_SENSOR_READY, 32'd1);
                end
            end
        end
        drain();

        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/thca_pkg.sv
hw/rtl/thca_if.sv
hw/rtl/thca_mul.sv
hw/rtl/thca_div.sv
hw/rtl/thca_sqrt.sv
hw/rtl/thca_cordic.sv
hw/rtl/tilt_compensated_heading_average.sv
test/tb_top.sv
